### rtl/core/ppmb_pkg.sv
// Package for the per-process mailbox engine: opcodes, states, status codes
// and the request/result structs. No dependencies.
`default_nettype none
package ppmb_pkg;

  typedef enum logic [2:0] {
    OP_SEND = 3'd0, OP_RECV = 3'd1, OP_BCAST = 3'd2, OP_SET = 3'd3, OP_QUERY = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_READY = 3'd0, ST_RUNNING = 3'd1, ST_BLOCKED = 3'd2, ST_WAITING = 3'd3,
    ST_TERMINATED = 3'd4
  } pstate_e;

  typedef enum logic [2:0] {
    STS_OK = 3'd0, STS_BAD_RX = 3'd1, STS_RX_TERM = 3'd2, STS_FULL = 3'd3,
    STS_EMPTY = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE, FSM_EXEC, FSM_BCAST, FSM_RDWAIT, FSM_OUT
  } fsm_e;

  localparam int unsigned InWidth  = 3 + 4 + 6 + 8 + 12 + 64 + 1 + 64 + 3 + 1;
  localparam int unsigned OutWidth = 3 + 4 + 4 + 8 + 4 + 64 + 64 + 4 + 3 + 32 + 32;

  typedef struct packed {
    logic        slot_used;
    logic [2:0]  new_state;
    logic [63:0] now_ns;
    logic        blocking;
    logic [63:0] payload;
    logic [11:0] req_size;
    logic [7:0]  msg_code;
    logic [5:0]  target_pid;
    logic [3:0]  pid;
    logic [2:0]  opcode;
  } req_t;

  typedef struct packed {
    logic [31:0] received_total;
    logic [31:0] sent_total;
    logic [2:0]  proc_state_out;
    logic [3:0]  delivered;
    logic [63:0] got_stamp;
    logic [63:0] got_payload;
    logic [3:0]  got_size;
    logic [7:0]  got_type;
    logic [3:0]  to_pid;
    logic [3:0]  from_pid;
    logic [2:0]  status;
  } res_t;

  typedef struct packed {
    logic [3:0]  from_pid;
    logic [3:0]  to_pid;
    logic [7:0]  mtype;
    logic [3:0]  size;
    logic [63:0] payload;
    logic [63:0] stamp;
  } msg_t;

endpackage
`default_nettype wire

### rtl/core/per_process_mailbox_ipc.sv
// Per-process mailbox engine top level: sequencer, per-process tables.
// Depends on ppmb_pkg and ppmb_slot_ram.
//
// Usage:
//  s_axis: one request beat per tdata (opcode, pid, target_pid, msg_code,
//  req_size, payload, blocking, now_ns, new_state, slot_used). m_axis: one
//  result beat per request. cfg_we_i/cfg_wdata_i write broadcast_type_code.
//  Sequence: send, set, query and undefined opcodes go from the execute state
//  straight to the output state; receive passes a read-wait state (slot memory
//  read is registered); broadcast walks every process, one process visited
//  per cycle by the shared enqueue path, before output. After each result the
//  block returns to idle before it accepts the next request.
//  s_axis_tready is high only in idle, so one request is in flight at a
//  time. The result sits in an output register until taken; a stalled
//  receiver holds the block in its output state.
//  Reset: every process terminated and unused, queues empty, counters zero,
//  broadcast type 255. Slot memory is not cleared; queue counts gate reads.
`default_nettype none
module per_process_mailbox_ipc #(
  parameter int unsigned PROCESSES     = 16,
  parameter int unsigned QUEUE_DEPTH   = 8,
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // low to high: opcode3 pid4 target_pid6 msg_code8 req_size12 payload64
  // blocking1 now_ns64 new_state3 slot_used1, 166 bits padded to 168
  input  wire logic [167:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // low to high: status3 from_pid4 to_pid4 got_type8 got_size4 got_payload64
  // got_stamp64 delivered4 proc_state_out3 sent_total32 received_total32,
  // 222 bits padded to 224
  output logic [223:0]     m_axis_tdata
);
  import ppmb_pkg::*;

  localparam int unsigned PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SLOTS = PROCESSES * QUEUE_DEPTH;
  localparam int unsigned SW = $clog2(SLOTS);

  logic [7:0] btype_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) btype_q <= 8'hff;
    else if (cfg_we_i) btype_q <= cfg_wdata_i;
  end

  // per-process tables
  logic [QW-1:0] head_q [PROCESSES];
  logic [QW-1:0] tail_q [PROCESSES];
  logic [CW-1:0] cnt_q  [PROCESSES];
  pstate_e       pst_q  [PROCESSES];
  logic          used_q [PROCESSES];
  logic [31:0]   sent_q [PROCESSES];
  logic [31:0]   recv_q [PROCESSES];

  fsm_e state_q, state_d;
  req_t req_q;
  res_t res_q, res_d;
  logic [PW:0] idx_q, idx_d;
  logic [3:0]  dlv_q, dlv_d;

  assign s_axis_tready = (state_q == FSM_IDLE);
  assign m_axis_tvalid = (state_q == FSM_OUT);
  assign m_axis_tdata  = {2'b00, res_q};

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  logic pid_ok;
  logic [PW-1:0] pid;
  assign pid_ok = {3'b000, req_q.pid} < 7'(PROCESSES);
  assign pid    = PW'(req_q.pid);

  // shared enqueue unit: one receiver per cycle
  logic [PW:0]   enq_rx_w;
  logic [PW-1:0] enq_rx;
  logic          enq_try, enq_ok;
  status_e       enq_sts;
  logic [3:0]    enq_size;
  always_comb begin
    enq_rx_w = (state_q == FSM_BCAST) ? idx_q : (PW+1)'(req_q.target_pid);
    enq_rx   = enq_rx_w[PW-1:0];
    enq_size = (req_q.req_size < 12'(PAYLOAD_BYTES)) ? req_q.req_size[3:0]
                                                    : 4'(PAYLOAD_BYTES);
    enq_try  = 1'b0;
    if (state_q == FSM_EXEC && req_q.opcode == OP_SEND && pid_ok) enq_try = 1'b1;
    if (state_q == FSM_BCAST && idx_q < (PW+1)'(PROCESSES) && enq_rx != pid &&
        pst_q[enq_rx] != ST_TERMINATED && used_q[enq_rx]) enq_try = 1'b1;
    if ({1'b0, req_q.target_pid} >= 7'(PROCESSES) && state_q == FSM_EXEC)
      enq_sts = STS_BAD_RX;
    else if (pst_q[enq_rx] == ST_TERMINATED) enq_sts = STS_RX_TERM;
    else if (cnt_q[enq_rx] >= CW'(QUEUE_DEPTH)) enq_sts = STS_FULL;
    else enq_sts = STS_OK;
    enq_ok = enq_try && (enq_sts == STS_OK);
  end

  logic [63:0] kept;
  always_comb begin
    for (int b = 0; b < 8; b++)
      kept[b*8 +: 8] = (4'(b) < enq_size) ? req_q.payload[b*8 +: 8] : 8'h00;
  end

  msg_t wmsg, rmsg;
  logic [SW-1:0] waddr, raddr;
  always_comb begin
    wmsg.from_pid = req_q.pid;
    wmsg.to_pid   = 4'(enq_rx);
    wmsg.mtype    = (state_q == FSM_BCAST) ? btype_q : req_q.msg_code;
    wmsg.size     = enq_size;
    wmsg.payload  = kept;
    wmsg.stamp    = req_q.now_ns;
    waddr = SW'(enq_rx) * SW'(QUEUE_DEPTH) + SW'(tail_q[enq_rx]);
    raddr = SW'(pid) * SW'(QUEUE_DEPTH) + SW'(head_q[pid]);
  end

  ppmb_slot_ram #(.Depth(SLOTS)) u_ram (
    .clk_i, .we_i(enq_ok), .waddr_i(waddr), .wdata_i(wmsg),
    .raddr_i(raddr), .rdata_o(rmsg)
  );

  logic do_deq, do_wait, do_set;
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    idx_d   = idx_q;
    dlv_d   = dlv_q;
    do_deq  = 1'b0;
    do_wait = 1'b0;
    do_set  = 1'b0;
    case (state_q)
      FSM_IDLE: if (in_fire) state_d = FSM_EXEC;
      FSM_EXEC: begin
        res_d   = '0;
        state_d = FSM_OUT;
        idx_d   = '0;
        dlv_d   = '0;
        if (req_q.opcode <= OP_QUERY && !pid_ok) res_d.status = STS_BAD_RX;
        else begin
          case (req_q.opcode)
            OP_SEND:  res_d.status = enq_sts;
            OP_RECV: begin
              if (cnt_q[pid] == '0) begin
                res_d.status = STS_EMPTY;
                do_wait = req_q.blocking;
              end else begin
                do_deq  = 1'b1;
                state_d = FSM_RDWAIT;
              end
            end
            OP_BCAST: state_d = FSM_BCAST;
            OP_SET:   do_set = 1'b1;
            OP_QUERY: begin
              res_d.proc_state_out = pst_q[pid];
              res_d.sent_total     = sent_q[pid];
              res_d.received_total = recv_q[pid];
            end
            default: ;
          endcase
        end
      end
      FSM_BCAST: begin
        if (idx_q >= (PW+1)'(PROCESSES)) begin
          res_d           = '0;
          res_d.delivered = dlv_q;
          state_d         = FSM_OUT;
        end else begin
          if (enq_ok && dlv_q != 4'd15) dlv_d = dlv_q + 4'd1;
          idx_d = idx_q + (PW+1)'(1);
        end
      end
      FSM_RDWAIT: begin
        res_d.from_pid    = rmsg.from_pid;
        res_d.to_pid      = rmsg.to_pid;
        res_d.got_type    = rmsg.mtype;
        res_d.got_size    = rmsg.size;
        res_d.got_payload = rmsg.payload;
        res_d.got_stamp   = rmsg.stamp;
        state_d = FSM_OUT;
      end
      FSM_OUT: if (m_axis_tready) state_d = FSM_IDLE;
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      idx_q   <= '0;
      dlv_q   <= '0;
      for (int p = 0; p < PROCESSES; p++) begin
        head_q[p] <= '0;
        tail_q[p] <= '0;
        cnt_q[p]  <= '0;
        pst_q[p]  <= ST_TERMINATED;
        used_q[p] <= 1'b0;
        sent_q[p] <= '0;
        recv_q[p] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      dlv_q   <= dlv_d;
      if (enq_ok) begin
        tail_q[enq_rx] <= (tail_q[enq_rx] == QW'(QUEUE_DEPTH - 1)) ? '0
                                                                  : tail_q[enq_rx] + QW'(1);
        cnt_q[enq_rx]  <= cnt_q[enq_rx] + CW'(1);
        sent_q[pid]    <= sent_q[pid] + 32'd1;
        if (pst_q[enq_rx] == ST_BLOCKED || pst_q[enq_rx] == ST_WAITING)
          pst_q[enq_rx] <= ST_READY;
      end
      if (do_deq) begin
        head_q[pid] <= (head_q[pid] == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q[pid] + QW'(1);
        cnt_q[pid]  <= cnt_q[pid] - CW'(1);
        recv_q[pid] <= recv_q[pid] + 32'd1;
      end
      if (do_wait) pst_q[pid] <= ST_WAITING;
      if (do_set) begin
        pst_q[pid]  <= (req_q.new_state > 3'd4) ? ST_TERMINATED : pstate_e'(req_q.new_state);
        used_q[pid] <= req_q.slot_used;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) req_q <= req_t'(s_axis_tdata[InWidth-1:0]);
    res_q <= res_d;
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready during output");
  a_exec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == FSM_EXEC) else $error("no exec after accept");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(res_q))
    else $error("result dropped");
  a_enq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_ok |-> cnt_q[enq_rx] < CW'(QUEUE_DEPTH)) else $error("overfill");
endmodule
`default_nettype wire

### rtl/core/ppmb_slot_ram.sv
// Message slot memory: one write port, one registered read port.
// Depends on ppmb_pkg for the message struct.
`default_nettype none
module ppmb_slot_ram #(
  parameter int unsigned Depth = 128
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(Depth)-1:0]   waddr_i,
  input  wire ppmb_pkg::msg_t             wdata_i,
  input  wire logic [$clog2(Depth)-1:0]   raddr_i,
  output ppmb_pkg::msg_t                  rdata_o
);
  import ppmb_pkg::*;

  msg_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### sim/testbench.sv
// Testbench for per_process_mailbox_ipc: directed and random request beats,
// with a scoreboard class that mirrors the mailbox tables. Depends on ppmb_pkg.
`timescale 1ns / 1ps
module testbench;
  import ppmb_pkg::*;

  localparam int NPROC = 16;
  localparam int QDEPTH = 8;
  localparam int PBYTES = 8;

  // Mailbox mirror: predicts each result beat and checks it in order.
  class mailbox_scoreboard;
    logic [2:0]  pst[NPROC];
    bit          used[NPROC];
    bit   [31:0] n_sent[NPROC];
    bit   [31:0] n_rcvd[NPROC];
    msg_t        mq[NPROC][$];
    logic [7:0]  bcast_type;
    res_t        expected_res[$];
    int          errors;

    function new();
      for (int i = 0; i < NPROC; i++) begin
        pst[i] = ST_TERMINATED;
        used[i] = 0;
        n_sent[i] = 0;
        n_rcvd[i] = 0;
      end
      bcast_type = 8'hff;
      errors = 0;
    endfunction

    function logic [2:0] enqueue(int from, int to, logic [7:0] mtype,
                                 logic [11:0] req, logic [63:0] data, logic [63:0] stamp);
      msg_t m;
      int sz;
      if (to >= NPROC) return STS_BAD_RX;
      if (pst[to] == ST_TERMINATED) return STS_RX_TERM;
      if (mq[to].size() >= QDEPTH) return STS_FULL;
      sz = (req < PBYTES) ? int'(req) : PBYTES;
      m.from_pid = 4'(from);
      m.to_pid = 4'(to);
      m.mtype = mtype;
      m.size = 4'(sz);
      // only the stored bytes survive
      m.payload = (sz >= 8) ? data : (data & ((64'd1 << (8 * sz)) - 64'd1));
      m.stamp = stamp;
      mq[to].push_back(m);
      n_sent[from]++;
      if (pst[to] == ST_BLOCKED || pst[to] == ST_WAITING) pst[to] = ST_READY;
      return STS_OK;
    endfunction

    function void note_request(req_t r);
      res_t e;
      msg_t m;
      int p, n;
      e = '0;
      p = r.pid;
      case (r.opcode)
        OP_SEND: e.status = enqueue(p, r.target_pid, r.msg_code, r.req_size,
                                    r.payload, r.now_ns);
        OP_RECV: begin
          if (mq[p].size() == 0) begin
            if (r.blocking) pst[p] = ST_WAITING;
            e.status = STS_EMPTY;
          end else begin
            m = mq[p].pop_front();
            e.from_pid = m.from_pid;
            e.to_pid = m.to_pid;
            e.got_type = m.mtype;
            e.got_size = m.size;
            e.got_payload = m.payload;
            e.got_stamp = m.stamp;
            n_rcvd[p]++;
          end
        end
        OP_BCAST: begin
          n = 0;
          for (int i = 0; i < NPROC; i++)
            if (i != p && pst[i] != ST_TERMINATED && used[i])
              if (enqueue(p, i, bcast_type, r.req_size, r.payload, r.now_ns) == STS_OK
                  && n < 15) n++;
          e.delivered = 4'(n);
        end
        OP_SET: begin
          pst[p] = (r.new_state > ST_TERMINATED) ? ST_TERMINATED : r.new_state;
          used[p] = r.slot_used;
        end
        OP_QUERY: begin
          e.proc_state_out = pst[p];
          e.sent_total = n_sent[p];
          e.received_total = n_rcvd[p];
        end
        default: ;
      endcase
      expected_res.push_back(e);
    endfunction

    function void check_result(res_t a);
      res_t e;
      logic [63:0] ev[11], av[11];
      string names[11];
      if (expected_res.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", a);
        return;
      end
      e = expected_res.pop_front();
      names = '{"status", "from_pid", "to_pid", "got_type", "got_size", "got_payload",
                "got_stamp", "delivered", "proc_state_out", "sent_total", "received_total"};
      ev = '{e.status, e.from_pid, e.to_pid, e.got_type, e.got_size, e.got_payload,
             e.got_stamp, e.delivered, e.proc_state_out, e.sent_total, e.received_total};
      av = '{a.status, a.from_pid, a.to_pid, a.got_type, a.got_size, a.got_payload,
             a.got_stamp, a.delivered, a.proc_state_out, a.sent_total, a.received_total};
      for (int i = 0; i < 11; i++)
        if (ev[i] !== av[i]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch %s: expected %h got %h", names[i], ev[i], av[i]);
        end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [7:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;  // req_t from bit 0, two pad bits on top
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [223:0] m_axis_tdata;       // res_t from bit 0, two pad bits on top

  mailbox_scoreboard sb = new();
  bit no_idle = 0;   // stretches with back-to-back beats on both sides

  per_process_mailbox_ipc dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // Hard limit, far above the slowest legal run.
  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

  // Gap lengths: mostly none or short, now and then long.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, checked at the rising edge.
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 0;
    else m_axis_tready <= (pick_gap() == 0);
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(res_t'(m_axis_tdata[OutWidth-1:0]));

  function req_t make_req(op_e op, int pid, int tgt, int nst, bit uflag);
    req_t r;
    r.opcode = op;
    r.pid = 4'(pid);
    r.target_pid = 6'(tgt);
    r.msg_code = 8'($urandom);
    r.req_size = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 9));
    r.payload = {$urandom, $urandom};
    r.blocking = 1'($urandom);
    r.now_ns = {$urandom, $urandom};
    r.new_state = 3'(nst);
    r.slot_used = uflag;
    return r;
  endfunction

  // Drive one request beat; note it at the edge that accepts it.
  task automatic push_req(req_t r);
    int g;
    g = pick_gap();
    repeat (g) begin
      @(negedge clk_i);
      s_axis_tvalid = 0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1;
    s_axis_tdata = {2'b00, r};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(r);
  endtask

  // Drain everything, let the block settle, then write the broadcast type.
  task automatic write_bcast_type(logic [7:0] v);
    @(negedge clk_i);
    s_axis_tvalid = 0;
    while (sb.expected_res.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1;
    cfg_wdata_i = v;
    @(posedge clk_i);
    sb.bcast_type = v;
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  task automatic random_req();
    int r, p;
    r = $urandom_range(0, 99);
    p = $urandom_range(0, NPROC - 1);
    if (r < 36)
      push_req(make_req(OP_SEND, p, ($urandom_range(0, 19) == 0) ?
                        $urandom_range(0, 63) : $urandom_range(0, NPROC - 1), 0, 0));
    else if (r < 68) push_req(make_req(OP_RECV, p, $urandom_range(0, 63), 0, 0));
    else if (r < 73) push_req(make_req(OP_BCAST, p, $urandom_range(0, 63), 0, 0));
    else if (r < 84)
      // mostly live states so that sends land
      push_req(make_req(OP_SET, p, $urandom_range(0, 63),
                        ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 3),
                        ($urandom_range(0, 5) != 0)));
    else if (r < 97) push_req(make_req(OP_QUERY, p, $urandom_range(0, 63), 0, 0));
    else push_req(make_req(op_e'($urandom_range(5, 7)), p, $urandom_range(0, 63),
                           $urandom_range(0, 7), 1'($urandom)));
  endtask

  initial begin
    req_t r;
    int waited;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed part, broadcast type still at its reset value.
    for (int i = 0; i < 4; i++) push_req(make_req(OP_SET, i, 0, ST_READY, 1));
    r = make_req(OP_SEND, 0, 1, 0, 0);
    r.req_size = 12'd3;                       // upper payload bytes dropped
    r.payload = '1;
    push_req(r);
    push_req(make_req(OP_SEND, 0, 63, 0, 0)); // receiver out of range
    push_req(make_req(OP_SEND, 0, 9, 0, 0));  // receiver terminated
    push_req(make_req(OP_RECV, 1, 0, 0, 0));
    r = make_req(OP_RECV, 1, 0, 0, 0);
    r.blocking = 1;                           // empty, caller goes waiting
    push_req(r);
    push_req(make_req(OP_QUERY, 1, 0, 0, 0));
    push_req(make_req(OP_SEND, 2, 1, 0, 0));  // wakes the waiting receiver
    push_req(make_req(OP_QUERY, 1, 0, 0, 0));
    r = make_req(OP_SEND, 0, 2, 0, 0);
    r.req_size = 12'hfff;
    r.payload = '1;
    r.now_ns = '1;
    r.msg_code = 8'hff;
    push_req(r);
    push_req(make_req(OP_SET, 5, 0, ST_BLOCKED, 0)); // live but not used
    push_req(make_req(OP_SEND, 3, 5, 0, 0));         // used flag not checked
    push_req(make_req(OP_SET, 6, 0, 7, 1));          // undefined state
    push_req(make_req(OP_QUERY, 6, 0, 0, 0));
    push_req(make_req(OP_BCAST, 0, 0, 0, 0));
    r = make_req(OP_SEND, 15, 0, 0, 0);
    r = '1;                                          // undefined opcode, all ones
    push_req(r);
    for (int i = 0; i < QDEPTH + 1; i++) push_req(make_req(OP_SEND, 1, 3, 0, 0)); // fill
    push_req(make_req(OP_RECV, 3, 0, 0, 0));
    push_req(make_req(OP_QUERY, 3, 0, 0, 0));

    // Random part in phases, broadcast type changed between them.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_bcast_type(8'h00);
        1: write_bcast_type(8'hff);
        2: write_bcast_type(8'h5a);
        default: write_bcast_type(8'($urandom));
      endcase
      for (int i = 0; i < 185; i++) begin
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        random_req();
      end
    end
    @(negedge clk_i);
    s_axis_tvalid = 0;

    waited = 0;
    while (sb.expected_res.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (sb.expected_res.size() != 0) sb.errors++;
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

### filelist.f
rtl/core/ppmb_pkg.sv
rtl/core/ppmb_slot_ram.sv
rtl/core/per_process_mailbox_ipc.sv
sim/testbench.sv
